// File: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/oet_pkg.sv
// types, codes and constants of the ordered entry table
package oet_pkg;

    localparam int DEF_CAPACITY = 32;
    localparam int DEF_MAX_ID   = 4095;

    localparam int OP_W     = 3;
    localparam int SQ_W     = 10;
    localparam int POS_W    = 6;
    localparam int TAG_W    = 32;
    localparam int ID_W     = 12;
    localparam int STATUS_W = 2;
    localparam int MI_W     = 5;
    localparam int CNT_W    = 6;
    localparam int NID_W    = 13;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 80;

    // cells examined per cycle by the find-last scan
    localparam int GROUP_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_FIND   = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_READ   = 3'd3,
        OP_ASSIGN = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_POS  = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic [SQ_W-1:0]  square;
        logic [TAG_W-1:0] tag;
        logic [ID_W-1:0]  id;
    } entry_t;

    typedef struct packed {
        logic take_lower;
        logic take_upper;
        logic load_new;
        logic load_id;
    } cell_ctrl_t;

endpackage

// File: src/oet_cell.sv
// one table cell: holds an entry, shifts to or from its neighbours and compares its square
module oet_cell (
    input  logic                         clk,
    input  oet_pkg::cell_ctrl_t          ctrl,
    input  oet_pkg::entry_t              lower,
    input  oet_pkg::entry_t              upper,
    input  oet_pkg::entry_t              new_entry,
    input  logic [oet_pkg::ID_W-1:0]     id_value,
    input  logic [oet_pkg::SQ_W-1:0]     key,
    output oet_pkg::entry_t              entry,
    output logic                         hit
);

    oet_pkg::entry_t entry_reg;
    oet_pkg::entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load_new)
        begin
            entry_next = new_entry;
        end
        else if (ctrl.take_lower)
        begin
            entry_next = lower;
        end
        else if (ctrl.take_upper)
        begin
            entry_next = upper;
        end
        else if (ctrl.load_id)
        begin
            entry_next.id = id_value;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign hit   = (entry_reg.square == key);

endmodule

// File: src/ordered_entry_table_top.sv
// ordered entry table: a chain of entry cells with insert, remove, find, read and id numbering
// insert, remove, read and assign-ids latch the request, execute it and register the result for output
// find-last latches the hit vector, then scans it 8 cells per cycle from the top until a hit or the bottom group
// a new request is taken only in idle, once the last result has entered the output register
// the input side is held while a request runs and while its result cannot enter the output register
// rst_n clears the count and the control state; entry contents are not cleared
module ordered_entry_table_top #(
    parameter int CAPACITY = oet_pkg::DEF_CAPACITY,
    parameter int MAX_ID   = oet_pkg::DEF_MAX_ID
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // square_value[9:0], position[15:10], entry_tag[47:16], id_base[59:48], zero pad
    input  logic [oet_pkg::IN_TDATA_W-1:0]     s_tdata,
    // opcode[2:0]
    input  logic [oet_pkg::OP_W-1:0]           s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // found[0], match_index[5:1], entry_count[11:6], out_square[21:12],
    // out_tag[53:22], out_id[65:54], next_id[78:66], zero pad
    output logic [oet_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // status[1:0]
    output logic [oet_pkg::STATUS_W-1:0]       m_tuser
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int CMPW  = (CW > oet_pkg::POS_W) ? CW : oet_pkg::POS_W;
    localparam int SUMW  = ((oet_pkg::ID_W > CW) ? oet_pkg::ID_W : CW) + 1;
    localparam int NGRP  = (CAPACITY + oet_pkg::GROUP_W - 1) / oet_pkg::GROUP_W;
    localparam int GW    = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int BW    = $clog2(oet_pkg::GROUP_W);
    localparam int PADW  = NGRP * oet_pkg::GROUP_W;
    localparam int PAY_W = oet_pkg::SQ_W + oet_pkg::POS_W + oet_pkg::TAG_W + oet_pkg::ID_W;

    typedef struct packed {
        oet_pkg::status_t                status;
        logic                            found;
        logic [oet_pkg::MI_W-1:0]        match_index;
        logic [oet_pkg::CNT_W-1:0]       entry_count;
        logic [oet_pkg::SQ_W-1:0]        out_square;
        logic [oet_pkg::TAG_W-1:0]       out_tag;
        logic [oet_pkg::ID_W-1:0]        out_id;
        logic [oet_pkg::NID_W-1:0]       next_id;
    } result_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_HOLD
    } state_t;

    state_t                          state_reg;
    oet_pkg::op_t                    op_reg;
    logic [oet_pkg::SQ_W-1:0]        sq_reg;
    logic [oet_pkg::POS_W-1:0]       pos_reg;
    logic [oet_pkg::TAG_W-1:0]       tag_reg;
    logic [oet_pkg::ID_W-1:0]        base_reg;
    logic [CW-1:0]                   cnt_reg;
    logic [CW-1:0]                   cnt_next;
    logic [PADW-1:0]                 match_reg;
    logic [GW-1:0]                   grp_reg;
    logic                            out_valid_reg;
    result_t                         out_reg;
    result_t                         pend_reg;

    oet_pkg::entry_t                 cells [CAPACITY];
    logic [CAPACITY-1:0]             hits;
    logic [CAPACITY-1:0]             live;
    oet_pkg::entry_t                 new_entry;
    oet_pkg::entry_t                 rd_entry;

    logic [CMPW-1:0]                 pos_ext;
    logic [CMPW-1:0]                 cnt_ext;
    logic [SUMW-1:0]                 id_sum;
    oet_pkg::status_t                exec_status;
    logic                            exec_ok;
    logic                            ins_ok;
    logic                            rem_ok;
    logic                            asg_ok;
    result_t                         exec_res;

    logic [oet_pkg::GROUP_W-1:0]     grp_bits;
    logic                            grp_any;
    logic [BW-1:0]                   hi_idx;
    logic                            finish;
    result_t                         fin_res;
    logic                            out_free;

    assign pos_ext  = CMPW'(pos_reg);
    assign cnt_ext  = CMPW'(cnt_reg);
    assign id_sum   = SUMW'(base_reg) + SUMW'(cnt_reg);
    assign out_free = !out_valid_reg || m_tready;

    assign new_entry.square = sq_reg;
    assign new_entry.tag    = tag_reg;
    assign new_entry.id     = '0;

    // status of the latched request against the current table
    always_comb
    begin
        exec_status = oet_pkg::ST_OK;
        unique case (op_reg)
            oet_pkg::OP_INSERT:
            begin
                if (cnt_reg == CW'(CAPACITY))
                begin
                    exec_status = oet_pkg::ST_FULL;
                end
                else if (pos_ext > cnt_ext)
                begin
                    exec_status = oet_pkg::ST_BAD_POS;
                end
            end
            oet_pkg::OP_REMOVE, oet_pkg::OP_READ:
            begin
                if (pos_ext >= cnt_ext)
                begin
                    exec_status = oet_pkg::ST_BAD_POS;
                end
            end
            oet_pkg::OP_ASSIGN:
            begin
                if ((cnt_reg != '0) && (32'(id_sum) > 32'(MAX_ID) + 32'd1))
                begin
                    exec_status = oet_pkg::ST_OVERFLOW;
                end
            end
            default:
            begin
                exec_status = oet_pkg::ST_OK;
            end
        endcase
    end

    assign exec_ok = (state_reg == S_EXEC) && (exec_status == oet_pkg::ST_OK);
    assign ins_ok  = exec_ok && (op_reg == oet_pkg::OP_INSERT);
    assign rem_ok  = exec_ok && (op_reg == oet_pkg::OP_REMOVE);
    assign asg_ok  = exec_ok && (op_reg == oet_pkg::OP_ASSIGN);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ins_ok)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (rem_ok)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    // entry select for read
    always_comb
    begin
        rd_entry = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (CMPW'(i) == pos_ext)
            begin
                rd_entry = cells[i];
            end
        end
    end

    always_comb
    begin
        exec_res             = '0;
        exec_res.status      = exec_status;
        exec_res.entry_count = oet_pkg::CNT_W'(cnt_next);
        if (exec_status == oet_pkg::ST_OK)
        begin
            if (op_reg == oet_pkg::OP_READ)
            begin
                exec_res.out_square = rd_entry.square;
                exec_res.out_tag    = rd_entry.tag;
                exec_res.out_id     = rd_entry.id;
            end
            else if (op_reg == oet_pkg::OP_ASSIGN)
            begin
                exec_res.next_id = oet_pkg::NID_W'(id_sum);
            end
        end
    end

    // chain of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        oet_pkg::cell_ctrl_t       ctrl;
        oet_pkg::entry_t           lower;
        oet_pkg::entry_t           upper;
        logic [oet_pkg::ID_W-1:0]  id_value;

        if (i == 0)
        begin : g_first
            assign lower = '0;
        end
        else
        begin : g_lower
            assign lower = cells[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign upper = cells[i];
        end
        else
        begin : g_upper
            assign upper = cells[i+1];
        end

        assign ctrl.take_lower = ins_ok && (CMPW'(i) > pos_ext);
        assign ctrl.load_new   = ins_ok && (CMPW'(i) == pos_ext);
        assign ctrl.take_upper = rem_ok && (CMPW'(i) >= pos_ext);
        assign ctrl.load_id    = asg_ok;
        assign id_value        = oet_pkg::ID_W'(32'(base_reg) + 32'(i));
        assign live[i]         = (CMPW'(i) < cnt_ext);

        oet_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .lower     (lower),
            .upper     (upper),
            .new_entry (new_entry),
            .id_value  (id_value),
            .key       (sq_reg),
            .entry     (cells[i]),
            .hit       (hits[i])
        );
    end

    // find-last scan, one group of cells per cycle from the top down
    assign grp_bits = match_reg[32'(grp_reg) * oet_pkg::GROUP_W +: oet_pkg::GROUP_W];
    assign grp_any  = |grp_bits;

    always_comb
    begin
        hi_idx = '0;
        for (int b = 0; b < oet_pkg::GROUP_W; b++)
        begin
            if (grp_bits[b])
            begin
                hi_idx = BW'(b);
            end
        end
    end

    always_comb
    begin
        finish  = 1'b0;
        fin_res = exec_res;
        if ((state_reg == S_EXEC) && (op_reg != oet_pkg::OP_FIND))
        begin
            finish = 1'b1;
        end
        else if ((state_reg == S_SCAN) && (grp_any || (grp_reg == '0)))
        begin
            finish              = 1'b1;
            fin_res             = '0;
            fin_res.status      = oet_pkg::ST_OK;
            fin_res.found       = grp_any;
            fin_res.entry_count = oet_pkg::CNT_W'(cnt_reg);
            if (grp_any)
            begin
                fin_res.match_index = oet_pkg::MI_W'(32'(grp_reg) * oet_pkg::GROUP_W
                                                     + 32'(hi_idx));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= oet_pkg::OP_FIND;
            sq_reg        <= '0;
            pos_reg       <= '0;
            tag_reg       <= '0;
            base_reg      <= '0;
            match_reg     <= '0;
            grp_reg       <= '0;
            out_reg       <= '0;
            pend_reg      <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg    <= oet_pkg::op_t'(s_tuser);
                        {base_reg, tag_reg, pos_reg, sq_reg} <= s_tdata[PAY_W-1:0];
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (op_reg == oet_pkg::OP_FIND)
                    begin
                        match_reg <= PADW'(hits & live);
                        grp_reg   <= GW'(NGRP - 1);
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (!finish)
                    begin
                        grp_reg <= grp_reg - GW'(1);
                    end
                end
                S_HOLD:
                begin
                    if (out_free)
                    begin
                        out_reg   <= pend_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // a finished result goes out now or waits in the pending register
            if (finish)
            begin
                if (out_free)
                begin
                    out_reg   <= fin_res;
                    state_reg <= S_IDLE;
                end
                else
                begin
                    pend_reg  <= fin_res;
                    state_reg <= S_HOLD;
                end
            end

            if (finish || (state_reg == S_HOLD))
            begin
                if (out_free)
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = oet_pkg::OUT_TDATA_W'({out_reg.next_id, out_reg.out_id, out_reg.out_tag,
                                             out_reg.out_square, out_reg.entry_count,
                                             out_reg.match_index, out_reg.found});

endmodule

// File: src/oet_checker.sv
// port-level checks of the ordered entry table, bound to the top level
`include "assert_macros.svh"

module oet_checker #(
    parameter int CAPACITY = oet_pkg::DEF_CAPACITY
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [oet_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input logic [oet_pkg::STATUS_W-1:0]       m_tuser
);

    logic                          stalled;
    logic                          is_full;
    logic                          is_ovf;
    logic                          res_found;
    logic [oet_pkg::MI_W-1:0]      res_index;
    logic [oet_pkg::CNT_W-1:0]     res_count;
    logic [oet_pkg::NID_W-1:0]     res_next_id;

    assign stalled     = m_tvalid && !m_tready;
    assign is_full     = m_tvalid && (m_tuser == oet_pkg::ST_FULL);
    assign is_ovf      = m_tvalid && (m_tuser == oet_pkg::ST_OVERFLOW);
    assign res_found   = m_tdata[0];
    assign res_index   = m_tdata[5:1];
    assign res_count   = m_tdata[11:6];
    assign res_next_id = m_tdata[78:66];

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, stalled, m_tvalid && $stable({m_tuser, m_tdata}), "held result changed")
    // a match only comes with ok status
    `ASSERT_SAME(a_found_ok, m_tvalid && res_found, m_tuser == oet_pkg::ST_OK, "match with bad status")
    // no match gives index zero
    `ASSERT_SAME(a_miss_index, m_tvalid && !res_found, res_index == '0, "miss with nonzero index")
    // full table refusal reports a full count
    `ASSERT_SAME(a_full_count, is_full, res_count == oet_pkg::CNT_W'(CAPACITY), "full, short count")
    // id overflow gives no next id
    `ASSERT_SAME(a_ovf_nid, is_ovf, res_next_id == '0, "overflow with next id")

endmodule

bind ordered_entry_table_top oet_checker #(
    .CAPACITY (CAPACITY)
) u_oet_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
